/* hw/rtl/dupf_pkg.sv */
// Shared types and constants of the per-user duplicate identifier filter.
// Used by the controller, the datapath and the top level. No dependencies.
package dupf_pkg;

  localparam int ID_W     = 32;
  localparam int ACTION_W = 2;
  localparam int USER_W   = 4;

  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CHECK  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RECORD = 2'd2;

  typedef struct packed {
    logic load_in;
    logic init_wr;
    logic row_rd;
    logic row_wr;
    logic cmp_en;
    logic out_load;
  } dupf_cmd_t;

  typedef struct packed {
    logic init_last;
    logic out_free;
  } dupf_status_t;

endpackage

/* hw/rtl/dupf_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dupf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/dupf_ctrl.sv */
// Controller state machine of the duplicate identifier filter.
// Depends on dupf_pkg for the command and status structures.
module dupf_ctrl
  import dupf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  dupf_status_t status,
  output dupf_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_CMP,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state_r)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (status.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.row_rd = 1'b1;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        cmd.cmp_en = 1'b1;
        cmd.row_wr = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/dupf_dp.sv */
// Datapath of the duplicate identifier filter: input registers, the row store,
// the parallel compare over a user's window and the output register.
// Depends on dupf_pkg and dupf_ram.
module dupf_dp
  import dupf_pkg::*;
#(
  parameter int WINDOW_DEPTH = 32,
  parameter int USERS        = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [USER_W-1:0]   in_user,
  input  logic [ID_W-1:0]     in_msg_id,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_duplicate,
  input  dupf_cmd_t           cmd,
  output dupf_status_t        status
);

  localparam int PTR_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int ADDR_W  = (USERS > 1) ? $clog2(USERS) : 1;
  localparam int UEXT_W  = (ADDR_W > USER_W) ? ADDR_W : USER_W;
  localparam int DATA_W  = WINDOW_DEPTH * ID_W;
  localparam int ROW_W   = DATA_W + PTR_W;

  logic [ACTION_W-1:0]                 action_r;
  logic [ID_W-1:0]                     id_r;
  logic [ADDR_W-1:0]                   addr_r;
  logic                                in_range_r;
  logic [ADDR_W-1:0]                   init_cnt_r;
  logic [WINDOW_DEPTH-1:0]             hit_r;
  logic                                out_valid_r;
  logic                                out_dup_r;
  logic [UEXT_W-1:0]                   user_ext;
  logic [ROW_W-1:0]                    rd_row;
  logic [WINDOW_DEPTH-1:0][ID_W-1:0]   rd_win;
  logic [PTR_W-1:0]                    rd_ptr;
  logic [WINDOW_DEPTH-1:0][ID_W-1:0]   wr_win;
  logic [PTR_W-1:0]                    wr_ptr;
  logic [ROW_W-1:0]                    wr_row;
  logic                                wr_en;
  logic [ADDR_W-1:0]                   wr_addr;
  logic                                writes_row;

  assign user_ext = UEXT_W'(in_user);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      action_r   <= in_action;
      id_r       <= in_msg_id;
      addr_r     <= user_ext[ADDR_W-1:0];
      in_range_r <= (32'(in_user) < 32'(USERS));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cnt_r <= '0;
    end else if (cmd.init_wr) begin
      init_cnt_r <= init_cnt_r + ADDR_W'(1);
    end
  end

  assign rd_win = rd_row[DATA_W-1:0];
  assign rd_ptr = rd_row[ROW_W-1 -: PTR_W];

  always_comb begin
    wr_win         = rd_win;
    wr_win[rd_ptr] = id_r;
    if (rd_ptr == PTR_W'(WINDOW_DEPTH - 1)) begin
      wr_ptr = '0;
    end else begin
      wr_ptr = rd_ptr + PTR_W'(1);
    end
  end

  assign writes_row = (action_r == ACT_CLEAR) || (action_r == ACT_RECORD);
  assign wr_en      = cmd.init_wr || (cmd.row_wr && in_range_r && writes_row);
  assign wr_addr    = cmd.init_wr ? init_cnt_r : addr_r;
  assign wr_row     = (cmd.init_wr || (action_r == ACT_CLEAR)) ? '0 : {wr_ptr, wr_win};

  dupf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (USERS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_row),
    .rd_en   (cmd.row_rd),
    .rd_addr (addr_r),
    .rd_data (rd_row)
  );

  always_ff @(posedge clk) begin
    if (cmd.cmp_en) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        hit_r[i] <= (rd_win[i] == id_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_dup_r <= in_range_r && (action_r == ACT_CHECK) && (|hit_r);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_duplicate = out_dup_r;

  assign status.init_last = (init_cnt_r == ADDR_W'(USERS - 1));
  assign status.out_free  = !out_valid_r || out_ready;

endmodule

/* hw/rtl/per_user_duplicate_id_filter.sv */
// Top level of the per-user duplicate identifier filter.
// Depends on dupf_pkg, dupf_ctrl and dupf_dp.
//
// Each input beat carries an action (clear, check or record), a user slot and
// a 32-bit message identifier. Every user slot owns a ring of the last
// WINDOW_DEPTH identifiers, held as one row of a RAM together with its write
// pointer. Every input beat yields exactly one output beat: duplicate is set
// only when a check finds the identifier in the user's ring.
// An item goes through its steps in order: accept, row read, compare and row
// write-back, then loading of the output register. A new beat is taken only
// once the previous item has loaded its result into the output register.
// After reset the block writes a zero row into each of the USERS RAM rows
// and holds in_ready low meanwhile. A result waits in the output register
// while the receiver stalls; the next item is accepted and processed, and it
// waits in its final step until the output register is free.
module per_user_duplicate_id_filter
  import dupf_pkg::*;
#(
  parameter int WINDOW_DEPTH = 32,
  parameter int USERS        = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [USER_W-1:0]   in_user,
  input  logic [ID_W-1:0]     in_msg_id,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_duplicate
);

  dupf_cmd_t    cmd;
  dupf_status_t status;

  dupf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dupf_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .USERS        (USERS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_action     (in_action),
    .in_user       (in_user),
    .in_msg_id     (in_msg_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_duplicate (out_duplicate),
    .cmd           (cmd),
    .status        (status)
  );

endmodule
